[rtl/core/ltbd_pkg.sv]
package ltbd_pkg;

  localparam int unsigned HeadLen    = 22;
  localparam int unsigned SymLen     = 187;
  localparam int unsigned TotalLen   = HeadLen + SymLen;
  localparam int unsigned PayloadLen = 140;

  // fixed link prefix, one byte per position
  localparam logic [7:0] LinkHead [HeadLen] = '{
    8'h72, 8'h68, 8'h79, 8'h74, 8'h68, 8'h6d, 8'h6d, 8'h61, 8'h73, 8'h74, 8'h65,
    8'h72, 8'h3a, 8'h2f, 8'h2f, 8'h6a, 8'h6f, 8'h69, 8'h6e, 8'h2f, 8'h31, 8'h2f
  };

  localparam logic [2:0] StatusOk       = 3'd0;
  localparam logic [2:0] StatusLength   = 3'd1;
  localparam logic [2:0] StatusPrefix   = 3'd2;
  localparam logic [2:0] StatusSymbol   = 3'd3;
  localparam logic [2:0] StatusTrailing = 3'd4;
  localparam logic [2:0] StatusVersion  = 3'd5;
  localparam logic [2:0] StatusField    = 3'd6;

  localparam logic CfgIpv4Family = 1'b0;
  localparam logic CfgIpv6Family = 1'b1;

  localparam logic [7:0] VersionOne   = 8'h01;
  localparam logic [7:0] Ipv4MaxFirst = 8'd224;
  localparam logic [7:0] ByteAllOnes  = 8'hff;
  localparam logic [7:0] LinkLocalHi  = 8'hfe;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } ltbd_in_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic       done_res;
    logic       accepted;
    logic [2:0] status;
  } ltbd_out_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] index;
    logic [7:0] value;
  } ltbd_byte_t;

  // returns {ok, value}
  function automatic logic [6:0] sym_decode(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c inside {[8'h41:8'h5a]}) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7a]}) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2d) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h5f) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  // keeps the lowest nonzero code
  function automatic logic [2:0] err_merge(input logic [2:0] cur, input logic [2:0] code,
                                           input logic hit);
    logic [2:0] r;
    r = cur;
    if (hit && (cur == StatusOk || code < cur)) begin
      r = code;
    end
    return r;
  endfunction

endpackage

[rtl/core/ltbd_field_chk.sv]
module ltbd_field_chk
  import ltbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       clr_i,
  input  ltbd_byte_t byte_i,
  input  logic [7:0] ipv4_code_i,
  input  logic [7:0] ipv6_code_i,
  output logic       version_bad_o,
  output logic       fields_ok_o
);

  logic [63:0] expiry_q, expiry_d;
  logic [7:0]  family_q, family_d;
  logic [5:0]  nz_q, nz_d;
  logic [15:0] addr_q, addr_d;
  logic [4:0]  mark_q, mark_d;

  logic [7:0] idx, val, ofs;
  logic       nz;
  logic [7:0] a0, a1;
  logic       any0_9, any4_15, any_all, exp_ok;

  assign idx = byte_i.index;
  assign val = byte_i.value;
  assign nz  = val != 8'd0;
  assign ofs = idx - 8'd28;

  assign version_bad_o = byte_i.valid && idx == 8'd0 && val != VersionOne;

  always_comb begin
    expiry_d = expiry_q;
    family_d = family_q;
    nz_d     = nz_q;
    addr_d   = addr_q;
    mark_d   = mark_q;
    if (byte_i.valid) begin
      if (idx == 8'd1) begin
        family_d = val;
      end else if (idx inside {[8'd2:8'd3]}) begin
        nz_d[0] = nz_q[0] | nz;
      end else if (idx inside {[8'd4:8'd11]}) begin
        nz_d[1] = nz_q[1] | nz;
      end else if (idx inside {[8'd12:8'd19]}) begin
        nz_d[2] = nz_q[2] | nz;
      end else if (idx inside {[8'd20:8'd27]}) begin
        expiry_d = {expiry_q[55:0], val};
      end else if (idx inside {[8'd28:8'd43]}) begin
        if (ofs == 8'd0) begin
          addr_d[15:8] = val;
        end else if (ofs == 8'd1) begin
          addr_d[7:0] = val;
        end else if (ofs < 8'd4) begin
          mark_d[0] = mark_q[0] | nz;
        end else if (ofs < 8'd10) begin
          mark_d[1] = mark_q[1] | nz;
        end else begin
          mark_d[2] = mark_q[2] | nz;
        end
        if (ofs == 8'd10 && val == ByteAllOnes) mark_d[3] = 1'b1;
        if (ofs == 8'd11 && val == ByteAllOnes) mark_d[4] = 1'b1;
      end else if (idx inside {[8'd44:8'd75]}) begin
        nz_d[3] = nz_q[3] | nz;
      end else if (idx inside {[8'd76:8'd107]}) begin
        nz_d[4] = nz_q[4] | nz;
      end else if (idx inside {[8'd108:8'd139]}) begin
        nz_d[5] = nz_q[5] | nz;
      end
    end
  end

  // checks run on the state including this byte
  assign a0      = addr_d[15:8];
  assign a1      = addr_d[7:0];
  assign any0_9  = a0 != 8'd0 || a1 != 8'd0 || mark_d[1:0] != 2'b00;
  assign any4_15 = mark_d[2:1] != 2'b00;
  assign any_all = any0_9 || mark_d[2];
  // nonzero and at most 2^52
  assign exp_ok  = expiry_d != 64'd0 && expiry_d[63:53] == 11'd0 &&
                   !(expiry_d[52] && expiry_d[51:0] != 52'd0);

  always_comb begin
    fields_ok_o = 1'b0;
    if (exp_ok && nz_d == 6'h3f) begin
      if (family_d == ipv4_code_i) begin
        fields_ok_o = a0 != 8'd0 && a0 < Ipv4MaxFirst && !any4_15;
      end else if (family_d != ipv6_code_i || !any_all || a0 == ByteAllOnes ||
                   (a0 == LinkLocalHi && a1[7:6] == 2'b10)) begin
        fields_ok_o = 1'b0;
      end else begin
        fields_ok_o = any0_9 || mark_d[4:3] != 2'b11;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= '0;
      family_q <= '0;
      nz_q     <= '0;
      addr_q   <= '0;
      mark_q   <= '0;
    end else if (en_i) begin
      if (clr_i) begin
        expiry_q <= '0;
        family_q <= '0;
        nz_q     <= '0;
        addr_q   <= '0;
        mark_q   <= '0;
      end else begin
        expiry_q <= expiry_d;
        family_q <= family_d;
        nz_q     <= nz_d;
        addr_q   <= addr_d;
        mark_q   <= mark_d;
      end
    end
  end

  // an all-ones byte 10 or 11 is also a nonzero byte in 10-15
  ap_mark_needs_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mark_q[3] || mark_q[4]) |-> mark_q[2])
    else $error("address mark flags inconsistent");

  ap_expiry_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && clr_i |=> expiry_q == 64'd0 && nz_q == 6'd0 && mark_q == 5'd0)
    else $error("field state not cleared at end of link");

  ap_family_byte_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !clr_i && byte_i.valid && idx == 8'd1 |=> family_q == $past(val))
    else $error("family byte not captured");

endmodule

[rtl/core/link_token_base64url_decoder.sv]
// path: a character is held in the input register, and its result in the output register
// throughput: one character per cycle; the block holds input only while the output stalls
// the input register, decode logic and result register form a single pass per character
// reset: asynchronous, active low; decode state cleared, family codes set to 0 and 1
// after the result for a last character the decode state returns to its reset value
module link_token_base64url_decoder
  import ltbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ltbd_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ltbd_out_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic [7:0] ipv4_code_q, ipv6_code_q;

  logic      in_vld_q;
  ltbd_in_t  in_q;
  logic      out_vld_q;
  ltbd_out_t out_q, out_d;
  logic      out_ready, adv;

  logic [7:0]  char_cnt_q, char_cnt_d;
  logic [13:0] buf_q, buf_d, buf_shift, buf_out;
  logic [2:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  byte_cnt_q, byte_cnt_d;
  logic [2:0]  err_q, err_step, err_fin, status;

  logic [7:0] pos;
  logic       in_head, in_sym, head_err, sym_err, emit, fin, len_bad, trail_err;
  logic [6:0] sym;
  logic [3:0] cnt_sum, bit_rem;
  logic [7:0] pbyte;

  ltbd_byte_t byte_ev;
  logic       version_bad, fields_ok;

  assign out_ready  = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_ready;
  assign in_stall_o = in_vld_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipv4_code_q <= 8'd0;
      ipv6_code_q <= 8'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgIpv4Family) ipv4_code_q <= cfg_data_i;
      if (cfg_index_i == CfgIpv6Family) ipv6_code_q <= cfg_data_i;
    end
  end

  // per-character decode
  assign pos      = char_cnt_q;
  assign fin      = in_q.last;
  assign in_head  = pos < 8'(HeadLen);
  assign in_sym   = !in_head && pos < 8'(TotalLen);
  assign head_err = in_head && in_q.character != LinkHead[pos[4:0]];
  assign sym      = sym_decode(in_q.character);
  // a bad symbol still feeds zero bits to keep alignment
  assign sym_err  = in_sym && !sym[6];

  assign buf_shift = {buf_q[7:0], sym[5:0]};
  assign cnt_sum   = {1'b0, bit_cnt_q} + 4'd6;
  assign emit      = in_sym && cnt_sum >= 4'd8 && byte_cnt_q < 8'(PayloadLen);
  assign bit_rem   = emit ? cnt_sum - 4'd8 : cnt_sum;
  assign buf_out   = buf_shift >> bit_rem[2:0];
  assign pbyte     = buf_out[7:0];

  assign buf_d      = in_sym ? buf_shift : buf_q;
  assign bit_cnt_d  = in_sym ? bit_rem[2:0] : bit_cnt_q;
  assign byte_cnt_d = emit ? byte_cnt_q + 8'd1 : byte_cnt_q;
  assign char_cnt_d = (char_cnt_q == 8'hff) ? char_cnt_q : char_cnt_q + 8'd1;

  assign byte_ev.valid = emit;
  assign byte_ev.index = byte_cnt_q;
  assign byte_ev.value = pbyte;

  ltbd_field_chk u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .clr_i         (fin),
    .byte_i        (byte_ev),
    .ipv4_code_i   (ipv4_code_q),
    .ipv6_code_i   (ipv6_code_q),
    .version_bad_o (version_bad),
    .fields_ok_o   (fields_ok)
  );

  assign err_step = err_merge(err_merge(err_merge(err_q, StatusPrefix, head_err),
                                        StatusSymbol, sym_err),
                              StatusVersion, version_bad);

  assign len_bad   = pos != 8'(TotalLen - 1);
  assign trail_err = byte_cnt_d != 8'(PayloadLen) ||
                     (buf_d & ~(14'h3fff << bit_cnt_d)) != 14'd0;
  assign err_fin   = err_merge(err_merge(err_step, StatusTrailing, trail_err),
                               StatusField, !fields_ok);
  assign status    = len_bad ? StatusLength : err_fin;

  always_comb begin
    out_d.byte_valid   = emit;
    out_d.payload_byte = emit ? pbyte : 8'd0;
    out_d.byte_index   = emit ? byte_cnt_q : 8'd0;
    out_d.done_res     = fin;
    out_d.accepted     = fin && status == StatusOk;
    out_d.status       = fin ? status : StatusOk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      char_cnt_q <= '0;
      buf_q      <= '0;
      bit_cnt_q  <= '0;
      byte_cnt_q <= '0;
      err_q      <= StatusOk;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (adv) begin
        if (fin) begin
          char_cnt_q <= '0;
          buf_q      <= '0;
          bit_cnt_q  <= '0;
          byte_cnt_q <= '0;
          err_q      <= StatusOk;
        end else begin
          char_cnt_q <= char_cnt_d;
          buf_q      <= buf_d;
          bit_cnt_q  <= bit_cnt_d;
          byte_cnt_q <= byte_cnt_d;
          err_q      <= err_step;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_data_i;
    if (adv) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  ap_bit_cnt_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q[0] == 1'b0)
    else $error("odd leftover bit count");

  ap_byte_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_cnt_q <= 8'(PayloadLen))
    else $error("byte count past payload");

  ap_status_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.done_res |-> out_q.status == StatusOk && !out_q.accepted)
    else $error("status given before end of link");

  ap_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && fin |=> char_cnt_q == 8'd0 && byte_cnt_q == 8'd0 && err_q == StatusOk)
    else $error("state not cleared after last character");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import ltbd_pkg::*;

  localparam int unsigned CycleLimit = 300_000;
  localparam int FieldLo [6] = '{2, 4, 12, 44, 76, 108};
  localparam int FieldHi [6] = '{3, 11, 19, 75, 107, 139};

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  ltbd_in_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  ltbd_out_t  out_data_o;
  logic       cfg_we_i = 1'b0;
  logic       cfg_index_i = 1'b0;
  logic [7:0] cfg_data_i = 8'h00;

  link_token_base64url_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  ltbd_in_t    pending_chars [$];
  ltbd_out_t   expected_results [$];
  logic [7:0]  link_text [$];
  logic [7:0]  link_payload [140];
  int          queued_count = 0;
  int          fault_count = 0;
  int unsigned cycle_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_run = 0;
  int          free_run = 0;
  ltbd_out_t   got_res;
  ltbd_out_t   want_res;

  // family codes as the block holds them
  logic [7:0] v4_code = 8'h00;
  logic [7:0] v6_code = 8'h01;

  // decoder state of the link in progress
  logic [7:0]  cur_pos = '0;
  logic [13:0] bit_reg = '0;
  logic [2:0]  bit_fill = '0;
  logic [7:0]  bytes_out = '0;
  logic [2:0]  first_err = StatusOk;
  logic [63:0] expiry_acc = '0;
  logic [7:0]  family_seen = '0;
  logic [5:0]  field_nz = '0;
  logic [7:0]  addr_hi = '0;
  logic [7:0]  addr_lo = '0;
  logic [4:0]  addr_marks = '0;

  function automatic int b64_index(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "a" && c <= "z") return c - "a" + 26;
    if (c >= "0" && c <= "9") return c - "0" + 52;
    if (c == "-") return 62;
    if (c == "_") return 63;
    return -1;
  endfunction

  function automatic void flag_fault(input logic [2:0] code);
    if (first_err == StatusOk || code < first_err) first_err = code;
  endfunction

  function automatic ltbd_out_t decode_link_char(input ltbd_in_t req);
    ltbd_out_t   res;
    int          pos;
    int          sym;
    int          idx;
    logic [3:0]  fill;
    logic [7:0]  b;
    logic [13:0] leftover;
    logic        any0_9, any4_15, any_all, v4_ok, v6_ok, fam_ok, fields_good;
    res = '0;
    pos = cur_pos;
    if (pos < HeadLen) begin
      if (req.character != LinkHead[pos]) flag_fault(StatusPrefix);
    end else if (pos < TotalLen) begin
      sym = b64_index(req.character);
      if (sym < 0) begin
        flag_fault(StatusSymbol);
        sym = 0;
      end
      bit_reg = {bit_reg[7:0], 6'(sym)};
      fill = {1'b0, bit_fill} + 4'd6;
      if (fill >= 4'd8 && bytes_out < PayloadLen) begin
        fill = fill - 4'd8;
        b = 8'(bit_reg >> fill);
        res.byte_valid = 1'b1;
        res.payload_byte = b;
        res.byte_index = bytes_out;
        idx = bytes_out;
        if (idx == 0) begin
          if (b != VersionOne) flag_fault(StatusVersion);
        end else if (idx == 1) begin
          family_seen = b;
        end else if (idx < 4) begin
          field_nz[0] = field_nz[0] | (b != 8'h00);
        end else if (idx < 12) begin
          field_nz[1] = field_nz[1] | (b != 8'h00);
        end else if (idx < 20) begin
          field_nz[2] = field_nz[2] | (b != 8'h00);
        end else if (idx < 28) begin
          expiry_acc = {expiry_acc[55:0], b};
        end else if (idx < 44) begin
          if (idx == 28) addr_hi = b;
          else if (idx == 29) addr_lo = b;
          else if (idx < 32) addr_marks[0] = addr_marks[0] | (b != 8'h00);
          else if (idx < 38) addr_marks[1] = addr_marks[1] | (b != 8'h00);
          else addr_marks[2] = addr_marks[2] | (b != 8'h00);
          if (idx == 38 && b == ByteAllOnes) addr_marks[3] = 1'b1;
          if (idx == 39 && b == ByteAllOnes) addr_marks[4] = 1'b1;
        end else if (idx < 76) begin
          field_nz[3] = field_nz[3] | (b != 8'h00);
        end else if (idx < 108) begin
          field_nz[4] = field_nz[4] | (b != 8'h00);
        end else begin
          field_nz[5] = field_nz[5] | (b != 8'h00);
        end
        bytes_out = bytes_out + 8'd1;
      end
      bit_fill = fill[2:0];
    end
    if (cur_pos != 8'hff) cur_pos = cur_pos + 8'd1;

    if (req.last) begin
      if (pos + 1 != TotalLen) begin
        res.status = StatusLength;
      end else begin
        leftover = bit_reg & ((14'd1 << bit_fill) - 14'd1);
        if (bytes_out != PayloadLen || leftover != '0) flag_fault(StatusTrailing);
        any0_9 = addr_hi != 8'h00 || addr_lo != 8'h00 || addr_marks[1:0] != 2'b00;
        any4_15 = addr_marks[2:1] != 2'b00;
        any_all = any0_9 || addr_marks[2];
        v4_ok = addr_hi != 8'h00 && addr_hi < Ipv4MaxFirst && !any4_15;
        // ipv6 rejects: unspecified, multicast, fe80::/10, v4-mapped
        v6_ok = family_seen == v6_code && any_all && addr_hi != ByteAllOnes &&
                !(addr_hi == LinkLocalHi && addr_lo[7:6] == 2'b10) &&
                (any0_9 || addr_marks[4:3] != 2'b11);
        fam_ok = (family_seen == v4_code) ? v4_ok : v6_ok;
        fields_good = expiry_acc != 64'd0 && expiry_acc <= (64'd1 << 52) &&
                      field_nz == 6'h3f && fam_ok;
        if (!fields_good) flag_fault(StatusField);
        res.status = first_err;
      end
      res.done_res = 1'b1;
      res.accepted = res.status == StatusOk;
      cur_pos = '0;
      bit_reg = '0;
      bit_fill = '0;
      bytes_out = '0;
      first_err = StatusOk;
      expiry_acc = '0;
      family_seen = '0;
      field_nz = '0;
      addr_hi = '0;
      addr_lo = '0;
      addr_marks = '0;
    end
    return res;
  endfunction

  // sender: bursts of requests with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(decode_link_char(in_data_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_chars.pop_front();
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern: short stall runs between free runs of varying length
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_run != 0) begin
      stall_run--;
      out_stall_i <= 1'b1;
    end else if (free_run != 0) begin
      free_run--;
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b0;
      stall_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      free_run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_res = out_data_o;
      if (expected_results.size() == 0) begin
        $error("result with no request pending");
        fault_count++;
      end else begin
        want_res = expected_results.pop_front();
        if (got_res.byte_valid !== want_res.byte_valid) begin
          $error("byte_valid: expected %0d, got %0d", want_res.byte_valid, got_res.byte_valid);
          fault_count++;
        end
        if (got_res.payload_byte !== want_res.payload_byte) begin
          $error("payload_byte: expected %0d, got %0d", want_res.payload_byte,
                 got_res.payload_byte);
          fault_count++;
        end
        if (got_res.byte_index !== want_res.byte_index) begin
          $error("byte_index: expected %0d, got %0d", want_res.byte_index, got_res.byte_index);
          fault_count++;
        end
        if (got_res.done_res !== want_res.done_res) begin
          $error("done_res: expected %0d, got %0d", want_res.done_res, got_res.done_res);
          fault_count++;
        end
        if (got_res.accepted !== want_res.accepted) begin
          $error("accepted: expected %0d, got %0d", want_res.accepted, got_res.accepted);
          fault_count++;
        end
        if (got_res.status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, got_res.status);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_chars.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  task automatic write_family(input logic idx, input logic [7:0] code);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= code;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgIpv4Family) v4_code = code;
    else v6_code = code;
  endtask

  task automatic zero_bytes(input int lo, input int hi);
    for (int i = lo; i <= hi; i++) link_payload[i] = 8'h00;
  endtask

  // either fully random or a single nonzero byte
  task automatic fill_field(input int lo, input int hi);
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = lo; i <= hi; i++) link_payload[i] = (mode == 0) ? 8'h00 : 8'($urandom);
    if (mode == 0) link_payload[$urandom_range(lo, hi)] = 8'($urandom_range(1, 255));
  endtask

  task automatic build_link();
    int            kind;
    int            pick;
    int            at;
    logic [1121:0] stream;
    logic [5:0]    sv;
    logic [7:0]    c;
    logic [63:0]   expiry;
    logic [1:0]    trail;
    link_text.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 92) begin
      repeat ($urandom_range(1, 40)) link_text.push_back(8'($urandom));
      return;
    end

    link_payload[0] = VersionOne;
    case ($urandom_range(0, 5))
      0, 1: link_payload[1] = v4_code;
      5: link_payload[1] = 8'($urandom);
      default: link_payload[1] = v6_code;
    endcase
    for (int f = 0; f < 6; f++) fill_field(FieldLo[f], FieldHi[f]);
    case ($urandom_range(0, 3))
      0: expiry = 64'd1;
      1: expiry = 64'd1 << 52;
      default: expiry = {$urandom, $urandom} % (64'd1 << 52) + 64'd1;
    endcase
    fill_field(28, 43);
    if (link_payload[1] == v4_code) begin
      pick = $urandom_range(0, 2);
      link_payload[28] = (pick == 0) ? 8'd1 : (pick == 1) ? Ipv4MaxFirst - 8'd1 :
                         8'($urandom_range(1, 223));
      zero_bytes(32, 43);
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          // mapped-looking, byte 11 left random
          zero_bytes(28, 37);
          link_payload[38] = ByteAllOnes;
        end
        1: begin
          link_payload[28] = LinkLocalHi;
          link_payload[29] = 8'($urandom_range(192, 255));
        end
        default: ;
      endcase
    end

    trail = 2'b00;
    if (kind >= 35 && kind < 60) begin
      case ($urandom_range(0, 10))
        0: begin
          pick = $urandom_range(0, 5);
          zero_bytes(FieldLo[pick], FieldHi[pick]);
        end
        1: expiry = 64'd0;
        2: expiry = (64'd1 << 52) + 64'd1;
        3: expiry = '1;
        4: begin
          link_payload[1] = v4_code;
          zero_bytes(32, 43);
          pick = $urandom_range(0, 2);
          link_payload[28] = (pick == 0) ? 8'h00 : (pick == 1) ? Ipv4MaxFirst : ByteAllOnes;
        end
        5: begin
          link_payload[1] = v4_code;
          link_payload[28] = 8'($urandom_range(1, 223));
          zero_bytes(32, 43);
          link_payload[$urandom_range(32, 43)] = 8'($urandom_range(1, 255));
        end
        6: begin
          link_payload[1] = v6_code;
          zero_bytes(28, 43);
        end
        7: begin
          link_payload[1] = v6_code;
          link_payload[28] = ByteAllOnes;
        end
        8: begin
          link_payload[1] = v6_code;
          link_payload[28] = LinkLocalHi;
          link_payload[29] = 8'h80 | 8'($urandom_range(0, 63));
        end
        9: begin
          link_payload[1] = v6_code;
          zero_bytes(28, 37);
          link_payload[38] = ByteAllOnes;
          link_payload[39] = ByteAllOnes;
        end
        default: begin
          do c = 8'($urandom);
          while (c == v4_code || c == v6_code);
          link_payload[1] = c;
        end
      endcase
    end else if (kind >= 76 && kind < 82) begin
      trail = 2'($urandom_range(1, 3));
    end else if (kind >= 82 && kind < 86) begin
      link_payload[0] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(2, 255));
    end
    for (int i = 0; i < 8; i++) link_payload[20 + i] = expiry[63 - 8 * i -: 8];

    for (int i = 0; i < PayloadLen; i++) stream[1121 - 8 * i -: 8] = link_payload[i];
    stream[1:0] = trail;
    for (int i = 0; i < HeadLen; i++) link_text.push_back(LinkHead[i]);
    for (int s = 0; s < SymLen; s++) begin
      sv = stream[1121 - 6 * s -: 6];
      if (sv < 6'd26) c = 8'("A") + 8'(sv);
      else if (sv < 6'd52) c = 8'("a") + 8'(sv) - 8'd26;
      else if (sv < 6'd62) c = 8'("0") + 8'(sv) - 8'd52;
      else if (sv == 6'd62) c = "-";
      else c = "_";
      link_text.push_back(c);
    end

    if (kind >= 60 && kind < 68) begin
      at = $urandom_range(0, HeadLen - 1);
      link_text[at] = link_text[at] ^ 8'($urandom_range(1, 255));
    end else if (kind >= 68 && kind < 76) begin
      at = $urandom_range(HeadLen, TotalLen - 1);
      do c = 8'($urandom);
      while (b64_index(c) >= 0);
      link_text[at] = c;
    end else if (kind >= 86) begin
      if ($urandom_range(0, 1) == 0) begin
        at = ($urandom_range(0, 2) == 0) ? TotalLen - 1 : $urandom_range(1, TotalLen - 1);
        while (link_text.size() > at) void'(link_text.pop_back());
      end else begin
        // long enough at times to saturate the character count
        at = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 60);
        repeat (at) link_text.push_back(8'($urandom));
      end
    end
  endtask

  // a nonzero split holds the rest back until every result so far has come
  task automatic send_link(input int split);
    ltbd_in_t req;
    for (int i = 0; i < link_text.size(); i++) begin
      if (split > 0 && i == split) wait_drained();
      req.character = link_text[i];
      req.last = (i == link_text.size() - 1);
      pending_chars.push_back(req);
    end
    queued_count += link_text.size();
  endtask

  initial begin : stimulus
    logic [7:0] shared_code;
    bit         first_link;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // short links: length errors, extreme bytes, partial prefix
    link_text = '{8'h00};
    send_link(0);
    link_text = '{8'hff};
    send_link(0);
    link_text = '{LinkHead[0], LinkHead[1], LinkHead[2], 8'h80};
    send_link(0);
    link_text.delete();
    for (int i = 0; i < 12; i++) link_text.push_back(LinkHead[i]);
    send_link(0);

    for (int phase = 0; phase < 4; phase++) begin
      if (phase != 0) begin
        wait_drained();
        case (phase)
          1: begin
            write_family(CfgIpv4Family, 8'hff);
            write_family(CfgIpv6Family, 8'h00);
          end
          2: begin
            // equal codes: the ipv4 rules take precedence
            shared_code = 8'($urandom);
            write_family(CfgIpv4Family, shared_code);
            write_family(CfgIpv6Family, shared_code);
          end
          default: begin
            write_family(CfgIpv4Family, 8'($urandom));
            write_family(CfgIpv6Family, 8'($urandom));
          end
        endcase
        @(negedge clk_i);
      end
      first_link = 1'b1;
      while (queued_count < (phase + 1) * 240) begin
        build_link();
        send_link(first_link ? link_text.size() / 2 : 0);
        first_link = 1'b0;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
